>>> hw/rtl/pwbt_pkg.sv
// Package for the point window box tracker: coordinate width, window
// constants, command codes and the request/result payload structs.
// No dependencies.
`timescale 1ns / 1ps

package pwbt_pkg;

    // Coordinate width in bits (signed millimetres)
    localparam int COORD_BITS = 16;
    localparam int CMD_BITS   = 3;

    // Tracking window and result constants, millimetres
    localparam int WIN_X        = 50;
    localparam int WIN_Y        = 30;
    localparam int WIN_Z        = 50;
    localparam int MAX_Y_EXTENT = 100;
    localparam int OBJ_Z_LIFT   = 20;

    // Reset position of the track and plane, millimetres
    localparam int RESET_TRACK_X = 1000;
    localparam int RESET_TRACK_Y = 0;
    localparam int RESET_PLANE_Z = 200;

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_POINT     = 3'd0,
        CMD_END_FRAME = 3'd1,
        CMD_LOCK      = 3'd2,
        CMD_SET_PLANE = 3'd3,
        CMD_STOP      = 3'd4
    } cmd_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One input request
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        coord_t              px;
        coord_t              py;
        coord_t              pz;
    } item_t;

    // One result
    typedef struct packed {
        coord_t obj_x;
        coord_t obj_y;
        coord_t obj_z;
        coord_t box_x_min;
        coord_t box_x_max;
        coord_t box_y_min;
        coord_t box_y_max;
        coord_t box_z_min;
        coord_t box_z_max;
    } result_t;

endpackage

>>> hw/rtl/point_window_box_tracker_unit.sv
// Point window box tracker top level: request register, window test,
// box update and result register. Depends on pwbt_pkg.
`timescale 1ns / 1ps

// Takes one request per cycle while not stalled (point, end of frame, lock
// target, set plane height, stop) and, while tracking, keeps the running box
// of the points that fall inside the window around the track and above the
// plane. A request waits in the request register, where it is tested against
// the track state and folded into the box; then its result, if any, sits in
// the result register until taken. Throughput is one request per clock
// while no untaken result blocks the result register.
// Only an end of frame with kept points and a y extent under 100 mm gives
// a result, and that result also moves the track. The request register
// stalls only while an untaken result occupies the result register.
module point_window_box_tracker_unit
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             item_valid,
    output logic             item_ready,
    input  pwbt_pkg::item_t  item,

    output logic             result_valid,
    input  logic             result_ready,
    output pwbt_pkg::result_t result
);

    localparam int CW = pwbt_pkg::COORD_BITS;
    localparam int WW = CW + 2;

    localparam logic signed [WW-1:0] COORD_MAX_W = $signed({3'b000, {(CW-1){1'b1}}});
    localparam logic signed [WW-1:0] WIN_X_W     = WW'(pwbt_pkg::WIN_X);
    localparam logic signed [WW-1:0] WIN_Y_W     = WW'(pwbt_pkg::WIN_Y);
    localparam logic signed [WW-1:0] WIN_Z_W     = WW'(pwbt_pkg::WIN_Z);
    localparam logic signed [WW-1:0] MAX_EXT_W   = WW'(pwbt_pkg::MAX_Y_EXTENT);
    localparam logic signed [WW-1:0] LIFT_W      = WW'(pwbt_pkg::OBJ_Z_LIFT);

    // Sign extend a coordinate to the working width
    function automatic logic signed [WW-1:0] widen(input pwbt_pkg::coord_t v);
        widen = $signed({{2{v[CW-1]}}, v});
    endfunction

    // Request register
    logic              stage_valid_reg, stage_valid_next;
    pwbt_pkg::item_t   stage_reg, stage_next;

    // Track state
    logic              tracking_reg, tracking_next;
    logic              any_kept_reg, any_kept_next;
    pwbt_pkg::coord_t  track_x_reg, track_x_next;
    pwbt_pkg::coord_t  track_y_reg, track_y_next;
    pwbt_pkg::coord_t  plane_z_reg, plane_z_next;
    pwbt_pkg::coord_t  x_min_reg, x_min_next;
    pwbt_pkg::coord_t  x_max_reg, x_max_next;
    pwbt_pkg::coord_t  y_min_reg, y_min_next;
    pwbt_pkg::coord_t  y_max_reg, y_max_next;
    pwbt_pkg::coord_t  z_min_reg, z_min_next;
    pwbt_pkg::coord_t  z_max_reg, z_max_next;

    // Result register
    logic              res_valid_reg, res_valid_next;
    pwbt_pkg::result_t res_reg, res_next;

    // Working-width views
    logic signed [WW-1:0] x_w, y_w, z_w;
    logic signed [WW-1:0] tx_w, ty_w, pl_w;
    logic signed [WW-1:0] y_sum_w, y_ext_w, obj_z_w, obj_y_w;
    logic                 x_ok, y_ok, z_ok;
    logic                 is_point, is_eof, kept, emit;
    logic                 can_move, fire;
    pwbt_pkg::coord_t     obj_y, obj_z;

    // Handshake
    assign can_move     = !res_valid_reg || result_ready;
    assign fire         = stage_valid_reg && can_move;
    assign item_ready   = !stage_valid_reg || can_move;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Window test on the staged request
    assign x_w  = widen(stage_reg.px);
    assign y_w  = widen(stage_reg.py);
    assign z_w  = widen(stage_reg.pz);
    assign tx_w = widen(track_x_reg);
    assign ty_w = widen(track_y_reg);
    assign pl_w = widen(plane_z_reg);

    assign z_ok = (z_w >= pl_w) && (z_w <= pl_w + WIN_Z_W);
    assign x_ok = (x_w >= tx_w - WIN_X_W) && (x_w <= tx_w + WIN_X_W);
    assign y_ok = (y_w >= ty_w - WIN_Y_W) && (y_w <= ty_w + WIN_Y_W);

    assign is_point = (stage_reg.cmd == pwbt_pkg::CMD_POINT);
    assign is_eof   = (stage_reg.cmd == pwbt_pkg::CMD_END_FRAME);
    assign kept     = is_point && tracking_reg && x_ok && y_ok && z_ok;

    // End of frame: extent check, floored y midpoint, lifted z with saturation
    assign y_ext_w = widen(y_max_reg) - widen(y_min_reg);
    assign y_sum_w = widen(y_min_reg) + widen(y_max_reg);
    assign obj_y_w = y_sum_w >>> 1;
    assign obj_y   = obj_y_w[CW-1:0];
    assign obj_z_w = pl_w + LIFT_W;
    assign obj_z   = (obj_z_w > COORD_MAX_W) ? COORD_MAX_W[CW-1:0] : obj_z_w[CW-1:0];
    assign emit    = is_eof && tracking_reg && any_kept_reg && (y_ext_w < MAX_EXT_W);

    // Next state
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        tracking_next    = tracking_reg;
        any_kept_next    = any_kept_reg;
        track_x_next     = track_x_reg;
        track_y_next     = track_y_reg;
        plane_z_next     = plane_z_reg;
        x_min_next       = x_min_reg;
        x_max_next       = x_max_reg;
        y_min_next       = y_min_reg;
        y_max_next       = y_max_reg;
        z_min_next       = z_min_reg;
        z_max_next       = z_max_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;

        // Request register load / drain
        if (item_valid && item_ready)
        begin
            stage_valid_next = 1'b1;
            stage_next       = item;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end

        // Result register drain
        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        // Process the staged request
        if (fire)
        begin
            case (stage_reg.cmd)
                pwbt_pkg::CMD_POINT:
                begin
                    if (kept)
                    begin
                        any_kept_next = 1'b1;
                        if (!any_kept_reg || stage_reg.px < x_min_reg) x_min_next = stage_reg.px;
                        if (!any_kept_reg || stage_reg.px > x_max_reg) x_max_next = stage_reg.px;
                        if (!any_kept_reg || stage_reg.py < y_min_reg) y_min_next = stage_reg.py;
                        if (!any_kept_reg || stage_reg.py > y_max_reg) y_max_next = stage_reg.py;
                        if (!any_kept_reg || stage_reg.pz < z_min_reg) z_min_next = stage_reg.pz;
                        if (!any_kept_reg || stage_reg.pz > z_max_reg) z_max_next = stage_reg.pz;
                    end
                end
                pwbt_pkg::CMD_END_FRAME:
                begin
                    any_kept_next = 1'b0;
                    if (emit)
                    begin
                        res_valid_next     = 1'b1;
                        res_next.obj_x     = x_min_reg;
                        res_next.obj_y     = obj_y;
                        res_next.obj_z     = obj_z;
                        res_next.box_x_min = x_min_reg;
                        res_next.box_x_max = x_max_reg;
                        res_next.box_y_min = y_min_reg;
                        res_next.box_y_max = y_max_reg;
                        res_next.box_z_min = z_min_reg;
                        res_next.box_z_max = z_max_reg;
                        track_x_next       = x_min_reg;
                        track_y_next       = obj_y;
                    end
                end
                pwbt_pkg::CMD_LOCK:
                begin
                    track_x_next  = stage_reg.px;
                    track_y_next  = stage_reg.py;
                    plane_z_next  = stage_reg.pz;
                    tracking_next = 1'b1;
                    any_kept_next = 1'b0;
                end
                pwbt_pkg::CMD_SET_PLANE:
                begin
                    plane_z_next = stage_reg.pz;
                end
                pwbt_pkg::CMD_STOP:
                begin
                    tracking_next = 1'b0;
                    any_kept_next = 1'b0;
                end
                default:
                begin
                    // unused codes are dropped
                end
            endcase
        end
    end

    // Control and track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            tracking_reg    <= 1'b0;
            any_kept_reg    <= 1'b0;
            track_x_reg     <= CW'(pwbt_pkg::RESET_TRACK_X);
            track_y_reg     <= CW'(pwbt_pkg::RESET_TRACK_Y);
            plane_z_reg     <= CW'(pwbt_pkg::RESET_PLANE_Z);
            x_min_reg       <= '0;
            x_max_reg       <= '0;
            y_min_reg       <= '0;
            y_max_reg       <= '0;
            z_min_reg       <= '0;
            z_max_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
            tracking_reg    <= tracking_next;
            any_kept_reg    <= any_kept_next;
            track_x_reg     <= track_x_next;
            track_y_reg     <= track_y_next;
            plane_z_reg     <= plane_z_next;
            x_min_reg       <= x_min_next;
            x_max_reg       <= x_max_next;
            y_min_reg       <= y_min_next;
            y_max_reg       <= y_max_next;
            z_min_reg       <= z_min_next;
            z_max_reg       <= z_max_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        res_reg   <= res_next;
    end

endmodule
